### rtl/quaternion_swing_twist_split_assert.svh
// assertion macros for the twist split block
// no dependencies; included by the top level
`ifndef QUATERNION_SWING_TWIST_SPLIT_ASSERT_SVH
`define QUATERNION_SWING_TWIST_SPLIT_ASSERT_SVH

// implication checked on every rising edge outside reset
`define QST_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// invariant checked on every rising edge outside reset
`define QST_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

`endif

### rtl/qst_pkg.sv
// shared types, widths and helpers for the twist split block
// no dependencies
package qst_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DATA_W    = 16;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int DFULL_W   = PROD_W + 2;
	localparam int DMAG_W    = 18;
	localparam int SQ_OP_W   = 38;
	localparam int SQ_ROOT_W = SQ_OP_W / 2;
	localparam int SQ_REM_W  = SQ_ROOT_W + 3;
	localparam int DIV_W     = SQ_ROOT_W;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = DMAG_W + FRAC_BITS + 1;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int SQ_CELLS  = SQ_ROOT_W;
	localparam int DIV_CELLS = QUO_W;
	localparam int FRONT_LAT = 4;
	localparam int LATENCY   = FRONT_LAT + SQ_CELLS + 1 + DIV_CELLS + 1 + SQ_CELLS + 1;

	// register indexes
	localparam logic [1:0] REG_AXIS_X = 2'd0;
	localparam logic [1:0] REG_AXIS_Y = 2'd1;
	localparam logic [1:0] REG_AXIS_Z = 2'd2;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
	} qst_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] twist_w;
		logic signed [DATA_W-1:0] twist_x;
		logic signed [DATA_W-1:0] twist_y;
		logic signed [DATA_W-1:0] twist_z;
		logic                     degenerate;
	} qst_res_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
	} qst_axis_t;

	// side data that travels with a request through the cells
	typedef struct packed {
		logic                     degen;
		logic                     w_neg;
		logic                     d_neg;
		logic [DMAG_W-1:0]        dmag;
		logic signed [DATA_W-1:0] tx;
		logic signed [DATA_W-1:0] ty;
		logic signed [DATA_W-1:0] tz;
	} qst_tag_t;

	typedef struct packed {
		qst_tag_t             tag;
		logic [SQ_OP_W-1:0]   op;
		logic [SQ_REM_W-1:0]  rem;
		logic [SQ_ROOT_W-1:0] root;
	} qst_sq_t;

	typedef struct packed {
		qst_tag_t         tag;
		logic [QUO_W-1:0] num;
		logic [DIV_W-1:0] rem;
		logic [QUO_W-1:0] quo;
		logic [DIV_W-1:0] dvsr;
	} qst_div_t;

	// round v / 2^FRAC_BITS to nearest, ties away from zero, then saturate
	function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W:0] sv;
		logic [PROD_W:0]        mag;
		logic [PROD_W:0]        m;
		logic signed [DATA_W-1:0] r;
		sv  = {v[PROD_W-1], v};
		mag = sv[PROD_W] ? (PROD_W+1)'(-sv) : (PROD_W+1)'(sv);
		m   = (mag + (PROD_W+1)'(ONE / 2)) >> FRAC_BITS;
		if (!sv[PROD_W]) begin
			r = (m > (PROD_W+1)'(32767)) ? 16'sh7fff : DATA_W'(m);
		end else begin
			r = (m > (PROD_W+1)'(32768)) ? 16'sh8000 : DATA_W'(-m);
		end
		return r;
	endfunction

endpackage

### rtl/qst_sqrt_cell.sv
// one digit step of the pipelined integer square root
// depends on qst_pkg
module qst_sqrt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_i,
	input  qst_pkg::qst_sq_t sq_i,
	output logic             vld_o,
	output qst_pkg::qst_sq_t sq_o
);
	import qst_pkg::*;

	logic [SQ_REM_W-1:0] rem_sh;
	logic [SQ_REM_W-1:0] trial;
	qst_sq_t             nxt;

	// bring in two operand bits and try the next root bit
	always_comb begin
		rem_sh   = {sq_i.rem[SQ_REM_W-3:0], sq_i.op[SQ_OP_W-1 -: 2]};
		trial    = SQ_REM_W'({sq_i.root, 2'b01});
		nxt      = sq_i;
		nxt.op   = sq_i.op << 2;
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {sq_i.root[SQ_ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {sq_i.root[SQ_ROOT_W-2:0], 1'b0};
		end
	end

	// valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		sq_o <= nxt;
	end

endmodule

### rtl/qst_div_cell.sv
// one quotient bit of the pipelined restoring divider
// depends on qst_pkg
module qst_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_i,
	input  qst_pkg::qst_div_t dv_i,
	output logic              vld_o,
	output qst_pkg::qst_div_t dv_o
);
	import qst_pkg::*;

	logic [DIV_W:0] rem_sh;
	logic [DIV_W:0] diff;
	qst_div_t       nxt;

	// shift in one numerator bit and subtract the divisor if it fits
	always_comb begin
		rem_sh  = {dv_i.rem, dv_i.num[QUO_W-1]};
		diff    = rem_sh - {1'b0, dv_i.dvsr};
		nxt     = dv_i;
		nxt.num = dv_i.num << 1;
		if (rem_sh >= {1'b0, dv_i.dvsr}) begin
			nxt.rem = diff[DIV_W-1:0];
			nxt.quo = {dv_i.quo[QUO_W-2:0], 1'b1};
		end else begin
			nxt.rem = rem_sh[DIV_W-1:0];
			nxt.quo = {dv_i.quo[QUO_W-2:0], 1'b0};
		end
	end

	// valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else begin
			vld_o <= vld_i;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		dv_o <= nxt;
	end

endmodule

### rtl/qst_front.sv
// front stages: axis projection, rounding, squares and their sum
// depends on qst_pkg
module qst_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               vld_i,
	input  qst_pkg::qst_req_t  req,
	input  qst_pkg::qst_axis_t axis,
	output logic               vld_o,
	output qst_pkg::qst_sq_t   sq_o
);
	import qst_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [PROD_W-1:0] px_s1, py_s1, pz_s1;
	logic signed [DATA_W-1:0] w_s1;
	logic [DATA_W-1:0]        wmag_s2;
	logic [DMAG_W-1:0]        dmag_s2, dmag_s3;
	logic                     w_neg_s2, d_neg_s2, degen_s2;
	logic                     w_neg_s3, d_neg_s3, degen_s3;
	logic [PROD_W-1:0]        wsq_s3;
	logic [2*DMAG_W-1:0]      dsq_s3;

	logic signed [DFULL_W-1:0] dfull;
	logic [DFULL_W-1:0]        dmag_full;
	logic [DFULL_W-1:0]        drnd;
	logic [DMAG_W-1:0]         dm;
	logic [2*DMAG_W:0]         nsum;

	// projection sum and rounding of d
	always_comb begin
		dfull     = DFULL_W'(px_s1) + DFULL_W'(py_s1) + DFULL_W'(pz_s1);
		dmag_full = dfull[DFULL_W-1] ? DFULL_W'(-dfull) : DFULL_W'(dfull);
		drnd      = dmag_full + DFULL_W'(ONE / 2);
		dm        = drnd[FRAC_BITS +: DMAG_W];
		nsum      = (2*DMAG_W+1)'(wsq_s3) + (2*DMAG_W+1)'(dsq_s3);
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_o  <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_o  <= vld_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		px_s1 <= req.quat_x * axis.x;
		py_s1 <= req.quat_y * axis.y;
		pz_s1 <= req.quat_z * axis.z;
		w_s1  <= req.quat_w;

		wmag_s2  <= w_s1[DATA_W-1] ? DATA_W'(-w_s1) : DATA_W'(w_s1);
		dmag_s2  <= dm;
		w_neg_s2 <= w_s1[DATA_W-1];
		d_neg_s2 <= dfull[DFULL_W-1] && (dm != '0);
		degen_s2 <= (w_s1 == '0) && (dm == '0);

		wsq_s3   <= wmag_s2 * wmag_s2;
		dsq_s3   <= dmag_s2 * dmag_s2;
		dmag_s3  <= dmag_s2;
		w_neg_s3 <= w_neg_s2;
		d_neg_s3 <= d_neg_s2;
		degen_s3 <= degen_s2;

		sq_o.op        <= SQ_OP_W'(nsum);
		sq_o.rem       <= '0;
		sq_o.root      <= '0;
		sq_o.tag.degen <= degen_s3;
		sq_o.tag.w_neg <= w_neg_s3;
		sq_o.tag.d_neg <= d_neg_s3;
		sq_o.tag.dmag  <= dmag_s3;
		sq_o.tag.tx    <= '0;
		sq_o.tag.ty    <= '0;
		sq_o.tag.tz    <= '0;
	end

endmodule

### rtl/quaternion_swing_twist_split.sv
// top level of the twist split block: register port, cell chains, output stage
// depends on qst_pkg, qst_front, qst_sqrt_cell, qst_div_cell and the assert header
//
// channel   ports                                    handshake
// request   start, busy, req                         start && !busy
// result    done, res                                done, one cycle
// config    psel, penable, pwrite, paddr, pwdata     psel && penable && pwrite
//
// one request enters every cycle; busy stays low
// each result passes the front stages, a square root chain (one cell per
// root bit), the divider chain, a second root chain and the output register
// reset clears the valid line of every cell; payload registers are not reset
// results cannot be held off, so nothing in the pipeline ever stalls
`include "quaternion_swing_twist_split_assert.svh"

module quaternion_swing_twist_split (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  qst_pkg::qst_req_t req,
	output logic              done,
	output qst_pkg::qst_res_t res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import qst_pkg::*;

	qst_axis_t axis_q;

	logic     sq1_vld [0:SQ_CELLS];
	qst_sq_t  sq1     [0:SQ_CELLS];
	logic     dv_vld  [0:DIV_CELLS];
	qst_div_t dv      [0:DIV_CELLS];
	logic     sq2_vld [0:SQ_CELLS];
	qst_sq_t  sq2     [0:SQ_CELLS];

	logic                     post_vld_s1;
	qst_tag_t                 post_tag_s1;
	logic [2*QUO_W-1:0]       asq_s1;
	logic signed [PROD_W-1:0] pax_s1, pay_s1, paz_s1;

	logic [SQ_ROOT_W-1:0] s_div;
	logic [NUM_W-1:0]     numer;
	logic [QUO_W-1:0]     alpha_m;
	logic signed [DATA_W-1:0] alpha;
	logic [2*QUO_W-1:0]   r_val;
	logic [SQ_ROOT_W-1:0] t_rnd;
	qst_sq_t              sq2_in;
	qst_sq_t              last;

	assign busy   = 1'b0;
	assign pready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q.x <= '0;
			axis_q.y <= DATA_W'(ONE);
			axis_q.z <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_AXIS_X: axis_q.x <= pwdata[DATA_W-1:0];
				REG_AXIS_Y: axis_q.y <= pwdata[DATA_W-1:0];
				REG_AXIS_Z: axis_q.z <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr[3:2])
			REG_AXIS_X: prdata = {16'h0, axis_q.x};
			REG_AXIS_Y: prdata = {16'h0, axis_q.y};
			REG_AXIS_Z: prdata = {16'h0, axis_q.z};
			default:    prdata = '0;
		endcase
	end

	// projection and sum of squares
	qst_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (start && !busy),
		.req    (req),
		.axis   (axis_q),
		.vld_o  (sq1_vld[0]),
		.sq_o   (sq1[0])
	);

	// chain for s = floor(sqrt(w^2 + d^2))
	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq1
		qst_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq1_vld[i]),
			.sq_i   (sq1[i]),
			.vld_o  (sq1_vld[i+1]),
			.sq_o   (sq1[i+1])
		);
	end

	// divider operands: (|d| << FRAC_BITS + s/2) / s
	always_comb begin
		s_div = (sq1[SQ_CELLS].root == '0) ? SQ_ROOT_W'(1) : sq1[SQ_CELLS].root;
		numer = {1'b0, sq1[SQ_CELLS].tag.dmag, {FRAC_BITS{1'b0}}}
			+ NUM_W'(s_div >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else begin
			dv_vld[0] <= sq1_vld[SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		dv[0].tag  <= sq1[SQ_CELLS].tag;
		dv[0].rem  <= DIV_W'(numer[NUM_W-1:QUO_W]);
		dv[0].num  <= numer[QUO_W-1:0];
		dv[0].quo  <= '0;
		dv[0].dvsr <= s_div;
	end

	// chain for alpha magnitude
	for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
		qst_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (dv_vld[i]),
			.dv_i   (dv[i]),
			.vld_o  (dv_vld[i+1]),
			.dv_o   (dv[i+1])
		);
	end

	// clamp alpha, square it and scale the axis
	always_comb begin
		alpha_m = (dv[DIV_CELLS].quo > QUO_W'(ONE)) ? QUO_W'(ONE) : dv[DIV_CELLS].quo;
		alpha   = dv[DIV_CELLS].tag.d_neg ? -$signed({1'b0, alpha_m}) : $signed({1'b0, alpha_m});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			post_vld_s1 <= 1'b0;
		end else begin
			post_vld_s1 <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		post_tag_s1 <= dv[DIV_CELLS].tag;
		asq_s1      <= alpha_m * alpha_m;
		pax_s1      <= alpha * axis_q.x;
		pay_s1      <= alpha * axis_q.y;
		paz_s1      <= alpha * axis_q.z;
	end

	// operand 1 - alpha^2 and rounded vector part for the second root
	always_comb begin
		r_val         = (2*QUO_W)'(ONE * ONE) - asq_s1;
		sq2_in.tag    = post_tag_s1;
		sq2_in.tag.tx = rnd_sat(pax_s1);
		sq2_in.tag.ty = rnd_sat(pay_s1);
		sq2_in.tag.tz = rnd_sat(paz_s1);
		sq2_in.op     = SQ_OP_W'(r_val);
		sq2_in.rem    = '0;
		sq2_in.root   = '0;
	end

	assign sq2_vld[0] = post_vld_s1;
	assign sq2[0]     = sq2_in;

	// chain for the twist scalar
	for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq2
		qst_sqrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (sq2_vld[i]),
			.sq_i   (sq2[i]),
			.vld_o  (sq2_vld[i+1]),
			.sq_o   (sq2[i+1])
		);
	end

	// round the root to nearest and apply sign or the identity case
	always_comb begin
		last  = sq2[SQ_CELLS];
		t_rnd = last.root + SQ_ROOT_W'(last.rem > SQ_REM_W'(last.root));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= sq2_vld[SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (last.tag.degen) begin
			res.twist_w    <= DATA_W'(ONE);
			res.twist_x    <= '0;
			res.twist_y    <= '0;
			res.twist_z    <= '0;
			res.degenerate <= 1'b1;
		end else begin
			res.twist_w    <= last.tag.w_neg ? -$signed(DATA_W'(t_rnd)) : $signed(DATA_W'(t_rnd));
			res.twist_x    <= last.tag.tx;
			res.twist_y    <= last.tag.ty;
			res.twist_z    <= last.tag.tz;
			res.degenerate <= 1'b0;
		end
	end

	// checks
	`QST_ASSERT_IMP(a_latency, clk, arst_n, start && !busy, ##LATENCY done, "request lost in pipeline")
	`QST_ASSERT_IMP(a_identity, clk, arst_n, done && res.degenerate, (res.twist_w == DATA_W'(ONE)) && (res.twist_x == '0) && (res.twist_y == '0) && (res.twist_z == '0), "degenerate result is not identity")

endmodule
